>>> hw/rtl/scs_pkg.sv
// ----------------------------------------------------------------------------
// scs_pkg
// Shared types, codes and the ALU function of the 16-bit CPU step block.
// ----------------------------------------------------------------------------
package scs_pkg;

    localparam int MEM_WORDS_DEFAULT = 1024;
    localparam int NUM_REGS          = 8;
    localparam int REG_IDX_W         = 3;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STEP  = 2'd2;

    localparam logic [5:0] OP_ADD     = 6'd0;
    localparam logic [5:0] OP_SUB     = 6'd1;
    localparam logic [5:0] OP_MUL     = 6'd2;
    localparam logic [5:0] OP_DIV     = 6'd3;
    localparam logic [5:0] OP_EQ      = 6'd4;
    localparam logic [5:0] OP_NE      = 6'd5;
    localparam logic [5:0] OP_LT      = 6'd6;
    localparam logic [5:0] OP_GT      = 6'd7;
    localparam logic [5:0] OP_LE      = 6'd8;
    localparam logic [5:0] OP_GE      = 6'd9;
    localparam logic [5:0] OP_AND     = 6'd10;
    localparam logic [5:0] OP_OR      = 6'd11;
    localparam logic [5:0] OP_XOR     = 6'd12;
    localparam logic [5:0] OP_SHL     = 6'd13;
    localparam logic [5:0] OP_SHR     = 6'd14;
    localparam logic [5:0] OP_LOAD    = 6'd15;
    localparam logic [5:0] OP_STORE   = 6'd16;
    localparam logic [5:0] OP_SYSCALL = 6'd17;

    localparam logic [1:0] IOP_JUMP = 2'd0;
    localparam logic [1:0] IOP_JNZ  = 2'd1;
    localparam logic [1:0] IOP_MOVI = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] address;
        logic [15:0] data_word;
    } cmd_t;

    typedef struct packed {
        logic [15:0]          pc;
        logic [15:0]          instruction;
        logic                 halted;
        logic                 reg_write;
        logic [REG_IDX_W-1:0] reg_index;
        logic [15:0]          reg_value;
        logic                 mem_write;
        logic [15:0]          store_address;
        logic [15:0]          store_value;
    } rsp_t;

    typedef struct packed {
        logic        rd_en;
        logic [15:0] rd_addr;
        logic        wr_en;
        logic [15:0] wr_addr;
        logic [15:0] wr_data;
    } wmem_req_t;

    typedef struct packed {
        logic [REG_IDX_W-1:0] ra;
        logic [REG_IDX_W-1:0] rb;
        logic                 we;
        logic [REG_IDX_W-1:0] wa;
        logic [15:0]          wd;
    } rf_req_t;

    // Combinational ALU operations; divide is handled by the iterative divider.
    function automatic logic [15:0] alu_op(input logic [5:0] op, input logic [15:0] a,
                                           input logic [15:0] b);
        logic        sh_ok;
        logic [31:0] prod;
        logic [15:0] res;
        sh_ok = (b[15:4] == 12'd0);
        prod  = {16'd0, a} * {16'd0, b};
        case (op)
            OP_ADD:  res = a + b;
            OP_SUB:  res = a - b;
            OP_MUL:  res = prod[15:0];
            OP_EQ:   res = {15'd0, a == b};
            OP_NE:   res = {15'd0, a != b};
            OP_LT:   res = {15'd0, a < b};
            OP_GT:   res = {15'd0, a > b};
            OP_LE:   res = {15'd0, a <= b};
            OP_GE:   res = {15'd0, a >= b};
            OP_AND:  res = a & b;
            OP_OR:   res = a | b;
            OP_XOR:  res = a ^ b;
            OP_SHL:  res = sh_ok ? (a << b[3:0]) : 16'd0;
            OP_SHR:  res = sh_ok ? (a >> b[3:0]) : 16'd0;
            default: res = 16'd0;
        endcase
        return res;
    endfunction

endpackage

>>> hw/rtl/scs_word_mem.sv
// ----------------------------------------------------------------------------
// scs_word_mem
// Single-port-write, single-port-read word memory with registered read data
// and a zero-fill sweep after reset.
// ----------------------------------------------------------------------------
module scs_word_mem
    import scs_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  wmem_req_t   req,
    output logic [15:0] rd_data,
    output logic        clearing
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [AW-1:0] LAST_IDX = AW'(MEM_WORDS - 1);

    logic [15:0]   mem [MEM_WORDS];
    logic [15:0]   rd_data_reg;
    logic [AW-1:0] clr_idx_reg;
    logic [AW-1:0] clr_idx_next;
    logic          clr_busy_reg;
    logic          clr_busy_next;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;

    always_comb
    begin
        clr_idx_next  = clr_idx_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_idx_next = clr_idx_reg + AW'(1);
            if (clr_idx_reg == LAST_IDX)
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_idx_reg  <= clr_idx_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    assign wr_en   = clr_busy_reg | req.wr_en;
    assign wr_addr = clr_busy_reg ? clr_idx_reg : req.wr_addr[AW-1:0];
    assign wr_data = clr_busy_reg ? 16'd0 : req.wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr[AW-1:0]];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clr_busy_reg;

endmodule

>>> hw/rtl/scs_reg_file.sv
// ----------------------------------------------------------------------------
// scs_reg_file
// Eight-entry register file, two registered read ports, one write port.
// Entries never written read as zero.
// ----------------------------------------------------------------------------
module scs_reg_file
    import scs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rf_req_t     req,
    output logic [15:0] rd_a,
    output logic [15:0] rd_b
);

    logic [15:0]         regs [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [NUM_REGS-1:0] valid_next;
    logic [15:0]         rd_a_reg;
    logic [15:0]         rd_b_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (req.we)
        begin
            valid_next[req.wa] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            regs[req.wa] <= req.wd;
        end
        rd_a_reg <= valid_reg[req.ra] ? regs[req.ra] : 16'd0;
        rd_b_reg <= valid_reg[req.rb] ? regs[req.rb] : 16'd0;
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

>>> hw/rtl/scs_addr_wrap.sv
// ----------------------------------------------------------------------------
// scs_addr_wrap
// Reduces a 16-bit address modulo MEM_WORDS in two steps: a registered
// reciprocal-multiply quotient, then a multiply-subtract for the remainder.
// ----------------------------------------------------------------------------
module scs_addr_wrap
    import scs_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEFAULT
)
(
    input  logic        clk,
    input  logic [15:0] addr_in,
    output logic [15:0] addr_out
);

    // floor(2^32 / M) + 1 gives an exact quotient for any 16-bit input
    localparam logic [32:0] RECIP = 33'(((64'd1 << 32) / MEM_WORDS) + 1);
    localparam logic [16:0] MW    = 17'(MEM_WORDS);

    logic [48:0] prod;
    logic [15:0] quo_next;
    logic [15:0] quo_reg;
    logic [15:0] addr_reg;
    logic [32:0] qm;

    assign prod     = {33'd0, addr_in} * {16'd0, RECIP};
    assign quo_next = prod[47:32];

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        addr_reg <= addr_in;
    end

    assign qm       = {17'd0, quo_reg} * {16'd0, MW};
    assign addr_out = addr_reg - qm[15:0];

endmodule

>>> hw/rtl/scs_divider.sv
// ----------------------------------------------------------------------------
// scs_divider
// 16-bit unsigned restoring divider, one quotient bit per cycle.
// A zero divisor yields all ones.
// ----------------------------------------------------------------------------
module scs_divider
    import scs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);

    localparam logic [4:0] DIV_STEPS = 5'd16;

    logic [4:0]  cnt_reg;
    logic [4:0]  cnt_next;
    logic        done_reg;
    logic        done_next;
    logic [15:0] rem_reg;
    logic [15:0] rem_next;
    logic [15:0] quo_reg;
    logic [15:0] quo_next;
    logic [15:0] dvs_reg;
    logic [15:0] dvs_next;
    logic [16:0] trial;
    logic [16:0] diff;
    logic        ge;

    assign trial = {rem_reg, quo_reg[15]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            cnt_next = DIV_STEPS;
            rem_next = 16'd0;
            quo_next = dividend;
            dvs_next = divisor;
        end
        else if (cnt_reg != 5'd0)
        begin
            rem_next  = ge ? diff[15:0] : trial[15:0];
            quo_next  = {quo_reg[14:0], ge};
            cnt_next  = cnt_reg - 5'd1;
            done_next = (cnt_reg == 5'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 5'd0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> hw/rtl/sixteen_bit_cpu_step_top.sv
// ----------------------------------------------------------------------------
// sixteen_bit_cpu_step_top
// 16-bit, 8-register CPU that loads memory, starts, or executes one
// instruction per command transaction and returns one result transaction.
// ----------------------------------------------------------------------------
// One command is worked on at a time; a finished result waits in an output
// register while the next command is taken. After reset the word memory is
// zero-filled, and no command is taken while the fill runs.
// Start, or step while halted, goes straight to S_WB; load passes S_FWRAP
// and S_WB; an executed instruction passes S_FWRAP, S_DEC, S_EXEC and S_WB,
// with S_MWRAP for a load or store, plus S_LDW for a load, or S_DIV for a
// divide ahead of S_WB. These states follow from the registered read data of
// the word memory and register file, the registered address wrap stage ahead
// of every memory access, and the radix-2 divider.
module sixteen_bit_cpu_step_top
    import scs_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FWRAP = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_MWRAP = 3'd4;
    localparam logic [2:0] S_LDW   = 3'd5;
    localparam logic [2:0] S_DIV   = 3'd6;
    localparam logic [2:0] S_WB    = 3'd7;

    logic [2:0]           state_reg, state_next;
    logic [15:0]          pc_reg, pc_next;
    logic                 running_reg, running_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    rsp_t                 rsp_reg, rsp_next;
    logic [1:0]           act_reg, act_next;
    logic [15:0]          addr_reg, addr_next;
    logic [15:0]          data_reg, data_next;
    logic [15:0]          instr_reg, instr_next;
    logic [15:0]          maddr_reg, maddr_next;
    logic                 res_rw_reg, res_rw_next;
    logic [REG_IDX_W-1:0] res_ridx_reg, res_ridx_next;
    logic [15:0]          res_rval_reg, res_rval_next;
    logic                 res_mw_reg, res_mw_next;
    logic [15:0]          res_sval_reg, res_sval_next;
    logic                 res_halt_reg, res_halt_next;
    logic [15:0]          res_npc_reg, res_npc_next;

    logic                 clearing;
    logic [15:0]          mem_rd_data;
    logic [15:0]          rf_a;
    logic [15:0]          rf_b;
    logic [15:0]          wrap_in;
    logic [15:0]          wrap_out;
    logic                 div_start;
    logic                 div_done;
    logic [15:0]          div_quo;
    wmem_req_t            wmem_req;
    rf_req_t              rf_req;
    logic                 cmd_fire;
    logic                 commit;
    logic                 stepping;

    logic                 is_rtype;
    logic [5:0]           rop;
    logic [REG_IDX_W-1:0] rd;
    logic [1:0]           iop;
    logic [REG_IDX_W-1:0] rj;
    logic [9:0]           imm;
    logic [5:0]           dec_rop;

    assign is_rtype = ~instr_reg[15];
    assign rop      = instr_reg[14:9];
    assign rd       = instr_reg[8:6];
    assign iop      = instr_reg[14:13];
    assign rj       = instr_reg[12:10];
    assign imm      = instr_reg[9:0];
    assign dec_rop  = mem_rd_data[14:9];

    assign cmd_ready = (state_reg == S_IDLE) && !clearing;
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign commit    = (state_reg == S_WB) && (!rsp_valid_reg || rsp_ready);
    assign stepping  = (act_reg == ACT_STEP) && running_reg;

    assign wrap_in = (state_reg == S_EXEC) ? rf_a :
                     ((cmd.action == ACT_STEP) ? pc_reg : cmd.address);

    assign div_start = (state_reg == S_EXEC) && is_rtype && (rop == OP_DIV);

    always_comb
    begin
        wmem_req.rd_en   = ((state_reg == S_FWRAP) && (act_reg != ACT_LOAD)) ||
                           ((state_reg == S_MWRAP) && (rop == OP_LOAD));
        wmem_req.rd_addr = wrap_out;
        wmem_req.wr_en   = commit && ((act_reg == ACT_LOAD) || (stepping && res_mw_reg));
        wmem_req.wr_addr = maddr_reg;
        wmem_req.wr_data = (act_reg == ACT_LOAD) ? data_reg : res_sval_reg;

        // syscall reads r0 through port a
        if (mem_rd_data[15])
        begin
            rf_req.ra = mem_rd_data[12:10];
        end
        else if (dec_rop == OP_SYSCALL)
        begin
            rf_req.ra = '0;
        end
        else
        begin
            rf_req.ra = mem_rd_data[5:3];
        end
        rf_req.rb = mem_rd_data[2:0];
        rf_req.we = commit && stepping && res_rw_reg;
        rf_req.wa = res_ridx_reg;
        rf_req.wd = res_rval_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        running_next   = running_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        act_next       = act_reg;
        addr_next      = addr_reg;
        data_next      = data_reg;
        instr_next     = instr_reg;
        maddr_next     = maddr_reg;
        res_rw_next    = res_rw_reg;
        res_ridx_next  = res_ridx_reg;
        res_rval_next  = res_rval_reg;
        res_mw_next    = res_mw_reg;
        res_sval_next  = res_sval_reg;
        res_halt_next  = res_halt_reg;
        res_npc_next   = res_npc_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    act_next  = cmd.action;
                    addr_next = cmd.address;
                    data_next = cmd.data_word;
                    if ((cmd.action == ACT_LOAD) ||
                        ((cmd.action == ACT_STEP) && running_reg))
                    begin
                        state_next = S_FWRAP;
                    end
                    else
                    begin
                        state_next = S_WB;
                    end
                end
            end
            S_FWRAP:
            begin
                maddr_next = wrap_out;
                state_next = (act_reg == ACT_LOAD) ? S_WB : S_DEC;
            end
            S_DEC:
            begin
                instr_next = mem_rd_data;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                res_npc_next  = pc_reg + 16'd1;
                res_rw_next   = 1'b0;
                res_ridx_next = rd;
                res_rval_next = alu_op(rop, rf_a, rf_b);
                res_mw_next   = 1'b0;
                res_halt_next = 1'b0;
                res_sval_next = rf_b;
                state_next    = S_WB;
                if (is_rtype)
                begin
                    if (rop <= OP_LOAD)
                    begin
                        res_rw_next = 1'b1;
                    end
                    if (rop == OP_DIV)
                    begin
                        state_next = S_DIV;
                    end
                    if ((rop == OP_LOAD) || (rop == OP_STORE))
                    begin
                        state_next = S_MWRAP;
                    end
                    if (rop == OP_SYSCALL)
                    begin
                        res_halt_next = (rf_a == 16'd0);
                    end
                end
                else
                begin
                    case (iop)
                        IOP_JUMP:
                        begin
                            res_npc_next = {6'd0, imm};
                        end
                        IOP_JNZ:
                        begin
                            if (rf_a != 16'd0)
                            begin
                                res_npc_next = {6'd0, imm};
                            end
                        end
                        IOP_MOVI:
                        begin
                            res_rw_next   = 1'b1;
                            res_ridx_next = rj;
                            res_rval_next = {6'd0, imm};
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_MWRAP:
            begin
                maddr_next = wrap_out;
                if (rop == OP_STORE)
                begin
                    res_mw_next = 1'b1;
                    state_next  = S_WB;
                end
                else
                begin
                    state_next = S_LDW;
                end
            end
            S_LDW:
            begin
                res_rval_next = mem_rd_data;
                state_next    = S_WB;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_rval_next = div_quo;
                    state_next    = S_WB;
                end
            end
            S_WB:
            begin
                if (commit)
                begin
                    if (act_reg == ACT_START)
                    begin
                        pc_next      = addr_reg;
                        running_next = 1'b1;
                    end
                    else if (stepping)
                    begin
                        pc_next = res_npc_reg;
                        if (res_halt_reg)
                        begin
                            running_next = 1'b0;
                        end
                    end
                    rsp_next.pc            = pc_next;
                    rsp_next.halted        = !running_next;
                    rsp_next.instruction   = stepping ? instr_reg : 16'd0;
                    rsp_next.reg_write     = stepping && res_rw_reg;
                    rsp_next.reg_index     = (stepping && res_rw_reg) ? res_ridx_reg : '0;
                    rsp_next.reg_value     = (stepping && res_rw_reg) ? res_rval_reg : 16'd0;
                    rsp_next.mem_write     = stepping && res_mw_reg;
                    rsp_next.store_address = (stepping && res_mw_reg) ? maddr_reg : 16'd0;
                    rsp_next.store_value   = (stepping && res_mw_reg) ? res_sval_reg : 16'd0;
                    rsp_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pc_reg        <= 16'd0;
            running_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            running_reg   <= running_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg      <= rsp_next;
        act_reg      <= act_next;
        addr_reg     <= addr_next;
        data_reg     <= data_next;
        instr_reg    <= instr_next;
        maddr_reg    <= maddr_next;
        res_rw_reg   <= res_rw_next;
        res_ridx_reg <= res_ridx_next;
        res_rval_reg <= res_rval_next;
        res_mw_reg   <= res_mw_next;
        res_sval_reg <= res_sval_next;
        res_halt_reg <= res_halt_next;
        res_npc_reg  <= res_npc_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    scs_word_mem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_word_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (wmem_req),
        .rd_data  (mem_rd_data),
        .clearing (clearing)
    );

    scs_reg_file u_reg_file (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rf_req),
        .rd_a  (rf_a),
        .rd_b  (rf_b)
    );

    scs_addr_wrap #(
        .MEM_WORDS (MEM_WORDS)
    ) u_addr_wrap (
        .clk      (clk),
        .addr_in  (wrap_in),
        .addr_out (wrap_out)
    );

    scs_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (rf_a),
        .divisor  (rf_b),
        .done     (div_done),
        .quotient (div_quo)
    );

endmodule

>>> hw/rtl/scs_checker.sv
// ----------------------------------------------------------------------------
// scs_checker
// Port-level checks on the result channel of the CPU step block.
// ----------------------------------------------------------------------------
module scs_checker
    import scs_pkg::*;
#(
    parameter int MEM_WORDS = MEM_WORDS_DEFAULT
)
(
    input logic clk,
    input logic rst_n,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result transaction dropped before acceptance");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp))
        else $error("result payload changed while stalled");

    a_reg_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.reg_write |-> (rsp.reg_index == '0) && (rsp.reg_value == 16'd0))
        else $error("register fields set without a register write");

    a_store_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.mem_write |->
            (rsp.store_address == 16'd0) && (rsp.store_value == 16'd0))
        else $error("store fields set without a store");

    a_store_kind: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.mem_write |-> !rsp.reg_write && !rsp.instruction[15] &&
            ({16'd0, rsp.store_address} < 32'(MEM_WORDS)))
        else $error("store reported by a non-store or outside memory");

endmodule

bind sixteen_bit_cpu_step_top scs_checker #(
    .MEM_WORDS (MEM_WORDS)
) u_scs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
